>>> rtl/mips_subset_executor_assert.svh
// Assertion macros for the executor; define NO_ASSERTIONS to drop them.
`ifndef MIPS_SUBSET_EXECUTOR_ASSERT_SVH
`define MIPS_SUBSET_EXECUTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define MSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("mse check failed");
// Checked at every edge, reset included.
`define MSE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("mse check failed");
`else
`define MSE_ASSERT(lbl, prop)
`define MSE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/mse_pkg.sv
`default_nettype none
package mse_pkg;

    // item commands
    localparam logic [1:0] CMD_EXEC   = 2'd0;
    localparam logic [1:0] CMD_LD_REG = 2'd1;
    localparam logic [1:0] CMD_LD_MEM = 2'd2;

    // opcodes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // R-type functs (anything else adds)
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;

    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = 5;

    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } t_rf_wr;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_dm_ctl;

endpackage
`default_nettype wire

>>> rtl/mse_if.sv
`default_nettype none
interface mse_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [31:0]        instr;
    logic [11:0]        load_index;
    logic signed [31:0] load_value;

    modport source (output valid, cmd, instr, load_index, load_value, input ready);
    modport sink   (input valid, cmd, instr, load_index, load_value, output ready);
endinterface

interface mse_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        next_pc;
    logic               branch_taken;
    logic               wrote_reg;
    logic [4:0]         dest_reg;
    logic signed [31:0] write_value;
    logic               wrote_mem;
    logic [11:0]        mem_address;
    logic signed [31:0] mem_value;

    modport source (output valid, next_pc, branch_taken, wrote_reg, dest_reg, write_value,
                    wrote_mem, mem_address, mem_value, input ready);
    modport sink   (input valid, next_pc, branch_taken, wrote_reg, dest_reg, write_value,
                    wrote_mem, mem_address, mem_value, output ready);
endinterface
`default_nettype wire

>>> rtl/mse_regfile.sv
`default_nettype none
module mse_regfile (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_rd_en,
    input  wire logic [mse_pkg::RF_AW-1:0] i_rd_addr_a,
    input  wire logic [mse_pkg::RF_AW-1:0] i_rd_addr_b,
    input  wire mse_pkg::t_rf_wr          i_wr,
    output logic [31:0]                   o_rd_data_a,
    output logic [31:0]                   o_rd_data_b
);

    logic [31:0]                   r_mem [mse_pkg::RF_DEPTH];
    logic [mse_pkg::RF_DEPTH-1:0]  r_vld;
    logic [31:0]                   r_rdat_a;
    logic [31:0]                   r_rdat_b;
    logic [31:0]                   r_byp_data;
    logic                          r_va;
    logic                          r_vb;
    logic                          r_byp_a;
    logic                          r_byp_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rdat_a   <= r_mem[i_rd_addr_a];
            r_rdat_b   <= r_mem[i_rd_addr_b];
            r_byp_data <= i_wr.data;
        end
    end

    // never-written entries read as zero; same-edge write wins over the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_byp_a <= 1'b0;
            r_byp_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va    <= r_vld[i_rd_addr_a];
                r_vb    <= r_vld[i_rd_addr_b];
                r_byp_a <= i_wr.en && (i_wr.addr == i_rd_addr_a);
                r_byp_b <= i_wr.en && (i_wr.addr == i_rd_addr_b);
            end
        end
    end

    assign o_rd_data_a = r_byp_a ? r_byp_data : (r_va ? r_rdat_a : 32'd0);
    assign o_rd_data_b = r_byp_b ? r_byp_data : (r_vb ? r_rdat_b : 32'd0);

endmodule
`default_nettype wire

>>> rtl/mse_dmem.sv
`default_nettype none
module mse_dmem #(
    parameter int ADDR_BITS = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mse_pkg::t_dm_ctl     i_ctl,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [31:0]          i_wdata,
    output logic [31:0]               o_rdata,
    output logic                      o_busy
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    logic [31:0]          r_mem [MEM_WORDS];
    logic [31:0]          r_rdata;
    logic [ADDR_BITS-1:0] r_clr_cnt;
    logic                 r_busy;

    // zero sweep after reset, one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + ADDR_BITS'(1);
            if (r_clr_cnt == {ADDR_BITS{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_cnt] <= 32'd0;
        end else if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule
`default_nettype wire

>>> rtl/mips_subset_executor.sv
// Throughput: one item per cycle, except under output stall or the reset sweep;
//   register hazards resolved by forwarding from stage 2.
// Reset: PC cleared, register file reads zero, and the data memory is swept to zero;
//   no item is accepted until the sweep ends.
// Stage 2 is a register, so a stalled result still lets one more item into stage 1.
`default_nettype none
`include "mips_subset_executor_assert.svh"
module mips_subset_executor #(
    parameter int MEM_ADDR_BITS = 12
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    mse_in_if.sink     i_in,
    mse_out_if.source  o_out
);

    localparam int AW = MEM_ADDR_BITS;

    // ---------------- stage 1: operands available ----------------
    logic              r1_vld;
    logic [1:0]        r1_cmd;
    logic [31:0]       r1_instr;
    logic [11:0]       r1_lidx;
    logic [31:0]       r1_lval;
    logic [31:0]       r_pc;

    // ---------------- stage 2: output / writeback ----------------
    logic              r2_vld;
    logic              r2_wb_pend;
    logic [31:0]       r2_npc;
    logic              r2_taken;
    logic              r2_wreg;
    logic [4:0]        r2_dreg;
    logic [31:0]       r2_wval;
    logic              r2_wmem;
    logic [AW-1:0]     r2_maddr;
    logic [31:0]       r2_mval;
    logic              r2_is_lw;

    logic              w_accept;
    logic              w_s1_move;
    logic              w_dm_busy;
    logic [31:0]       w_rf_a;
    logic [31:0]       w_rf_b;
    logic [31:0]       w_dm_rdata;
    mse_pkg::t_rf_wr   w_rf_wr;
    mse_pkg::t_dm_ctl  w_dm_ctl;

    // decode
    logic [5:0]        w_op;
    logic [5:0]        w_fn;
    logic [4:0]        w_rs;
    logic [4:0]        w_rt;
    logic [4:0]        w_rd;
    logic [31:0]       w_imm;
    logic [31:0]       w_inc;
    logic [31:0]       w_a;
    logic [31:0]       w_b;
    logic [31:0]       w_alu;
    logic [31:0]       w_ea;
    logic [31:0]       w_lidx32;
    logic [31:0]       w_s2_val;
    logic [31:0]       w_maddr32;

    // stage-1 results heading into stage 2
    logic [31:0]       n_npc;
    logic              n_taken;
    logic              n_wreg;
    logic [4:0]        n_dreg;
    logic [31:0]       n_wval;
    logic              n_wmem;
    logic [AW-1:0]     n_maddr;
    logic [31:0]       n_mval;
    logic              n_is_lw;
    logic              n_dm_rd;
    logic              n_dm_wr;

    // handshake: stage 1 drains into stage 2 whenever stage 2 is empty or leaving
    assign w_s1_move   = r1_vld && (!r2_vld || o_out.ready);
    assign i_in.ready  = !w_dm_busy && (!r1_vld || w_s1_move);
    assign w_accept    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_accept) begin
            r1_vld <= 1'b1;
        end else if (w_s1_move) begin
            r1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_cmd   <= i_in.cmd;
            r1_instr <= i_in.instr;
            r1_lidx  <= i_in.load_index;
            r1_lval  <= i_in.load_value;
        end
    end

    // register file read is issued at accept, addressed straight from the item
    mse_regfile u_rf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (i_in.instr[25:21]),
        .i_rd_addr_b (i_in.instr[20:16]),
        .i_wr        (w_rf_wr),
        .o_rd_data_a (w_rf_a),
        .o_rd_data_b (w_rf_b)
    );

    assign w_op  = r1_instr[31:26];
    assign w_rs  = r1_instr[25:21];
    assign w_rt  = r1_instr[20:16];
    assign w_rd  = r1_instr[15:11];
    assign w_fn  = r1_instr[5:0];
    assign w_imm = {{16{r1_instr[15]}}, r1_instr[15:0]};
    assign w_inc = r_pc + 32'd1;

    // stage 2 holds the only older item not yet visible in the register read
    assign w_s2_val = (r2_is_lw && r2_wreg) ? w_dm_rdata : r2_wval;
    assign w_a = (r2_vld && r2_wreg && (r2_dreg == w_rs)) ? w_s2_val : w_rf_a;
    assign w_b = (r2_vld && r2_wreg && (r2_dreg == w_rt)) ? w_s2_val : w_rf_b;

    always_comb begin
        case (w_fn)
            mse_pkg::FN_SUB: w_alu = w_a - w_b;
            mse_pkg::FN_AND: w_alu = w_a & w_b;
            mse_pkg::FN_OR:  w_alu = w_a | w_b;
            default:         w_alu = w_a + w_b;
        endcase
    end

    // word addresses wrap to the memory depth
    assign w_ea     = w_a + w_imm;
    assign w_lidx32 = 32'(r1_lidx);

    always_comb begin
        n_npc   = r_pc;
        n_taken = 1'b0;
        n_wreg  = 1'b0;
        n_dreg  = 5'd0;
        n_wval  = 32'd0;
        n_wmem  = 1'b0;
        n_maddr = '0;
        n_mval  = 32'd0;
        n_is_lw = 1'b0;
        n_dm_rd = 1'b0;
        n_dm_wr = 1'b0;
        case (r1_cmd)
            mse_pkg::CMD_EXEC: begin
                n_npc = w_inc;
                case (w_op)
                    mse_pkg::OP_RTYPE: begin
                        if (w_rd != 5'd0) begin
                            n_wreg = 1'b1;
                            n_dreg = w_rd;
                            n_wval = w_alu;
                        end
                    end
                    mse_pkg::OP_LW: begin
                        // value arrives from the memory read in stage 2
                        n_maddr = w_ea[AW-1:0];
                        n_is_lw = 1'b1;
                        n_dm_rd = 1'b1;
                        if (w_rt != 5'd0) begin
                            n_wreg = 1'b1;
                            n_dreg = w_rt;
                        end
                    end
                    mse_pkg::OP_SW: begin
                        n_wmem  = 1'b1;
                        n_maddr = w_ea[AW-1:0];
                        n_mval  = w_b;
                        n_dm_wr = 1'b1;
                    end
                    mse_pkg::OP_BEQ: begin
                        if (w_a == w_b) begin
                            n_npc   = w_inc + w_imm;
                            n_taken = 1'b1;
                        end
                    end
                    mse_pkg::OP_J: begin
                        n_npc   = {w_inc[31:26], r1_instr[25:0]};
                        n_taken = 1'b1;
                    end
                    default: ;  // unknown opcode: no-op
                endcase
            end
            mse_pkg::CMD_LD_REG: begin
                // only registers 1..31; zero and out-of-range indexes are dropped
                if ((r1_lidx[11:5] == 7'd0) && (r1_lidx[4:0] != 5'd0)) begin
                    n_wreg = 1'b1;
                    n_dreg = r1_lidx[4:0];
                    n_wval = r1_lval;
                end
            end
            mse_pkg::CMD_LD_MEM: begin
                n_wmem  = 1'b1;
                n_maddr = w_lidx32[AW-1:0];
                n_mval  = r1_lval;
                n_dm_wr = 1'b1;
            end
            default: ;  // spare command: nothing happens
        endcase
    end

    // at most one memory access per item, issued as the item leaves stage 1
    assign w_dm_ctl.wr = w_s1_move && n_dm_wr;
    assign w_dm_ctl.rd = w_s1_move && n_dm_rd;

    mse_dmem #(
        .ADDR_BITS (AW)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dm_ctl),
        .i_addr  (n_maddr),
        .i_wdata (n_mval),
        .o_rdata (w_dm_rdata),
        .o_busy  (w_dm_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= 32'd0;
            r2_vld     <= 1'b0;
            r2_wb_pend <= 1'b0;
        end else begin
            r2_wb_pend <= w_s1_move;
            if (w_s1_move) begin
                r_pc   <= n_npc;
                r2_vld <= 1'b1;
            end else if (o_out.ready) begin
                r2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r2_npc   <= n_npc;
            r2_taken <= n_taken;
            r2_wreg  <= n_wreg;
            r2_dreg  <= n_dreg;
            r2_wval  <= n_wval;
            r2_wmem  <= n_wmem;
            r2_maddr <= n_maddr;
            r2_mval  <= n_mval;
            r2_is_lw <= n_is_lw;
        end
    end

    // writeback fires once, in the first cycle an item sits in stage 2
    assign w_rf_wr.en   = r2_vld && r2_wb_pend && r2_wreg;
    assign w_rf_wr.addr = r2_dreg;
    assign w_rf_wr.data = w_s2_val;

    assign w_maddr32 = 32'(r2_maddr);

    assign o_out.valid        = r2_vld;
    assign o_out.next_pc      = r2_npc;
    assign o_out.branch_taken = r2_taken;
    assign o_out.wrote_reg    = r2_wreg;
    assign o_out.dest_reg     = r2_dreg;
    assign o_out.write_value  = w_s2_val;
    assign o_out.wrote_mem    = r2_wmem;
    assign o_out.mem_address  = w_maddr32[11:0];
    assign o_out.mem_value    = r2_is_lw ? w_dm_rdata : r2_mval;

    // register zero is never reported as written
    `MSE_ASSERT(a_no_reg0_write, (o_out.valid && o_out.wrote_reg) |-> (o_out.dest_reg != 5'd0))
    // writeback only comes from a live stage-2 item
    `MSE_ASSERT_ALWAYS(a_wb_from_valid, w_rf_wr.en |-> (r2_vld && r2_wb_pend))
    // PC moves only when an item leaves stage 1
    `MSE_ASSERT(a_pc_hold, ($past(i_rst_n) && !$past(w_s1_move)) |-> $stable(r_pc))

endmodule
`default_nettype wire
